### rtl/core/arp_cache_responder_core_macros.svh
// Assertion macros for the ARP cache checker file.
`ifndef ARP_CACHE_RESPONDER_CORE_MACROS_SVH
`define ARP_CACHE_RESPONDER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define ARPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define ARPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### rtl/core/arpc_pkg.sv
// Types and constants shared by the ARP cache and responder modules.
package arpc_pkg;

  // ARP operation field codes.
  localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPC_REPLY   = 16'd2;

  // Item operation codes.
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_MAC = 1'b1;

  // Reset value of our IP address, 10.0.2.15.
  localparam logic [31:0] OUR_IP_RESET = 32'h0A00020F;

  // Depth of the command queue between front and back.
  localparam int CMD_FIFO_DEPTH = 2;

  // Input word.
  typedef struct packed {
    logic        operation;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } item_t;

  // Result word.
  typedef struct packed {
    logic        found;
    logic [47:0] found_mac;
    logic        reply_valid;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_dst_ip;
    logic        entry_dropped;
  } result_t;

  // Command kinds produced by the front end.
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_ANSWER = 2'd3
  } cmd_kind_e;

  // Classified command handed from front to back.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

endpackage

### rtl/core/arpc_stream_if.sv
// Valid/ready stream interface carrying one payload word.
interface arpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/arpc_front.sv
// Front end: accepts input words and classifies them into cache commands.
module arpc_front
  import arpc_pkg::*;
(
  input  logic [31:0]         our_ip_i,
  arpc_stream_if.sink         item_i,
  input  logic                full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  item_t item;

  assign item         = item_i.payload;
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // Decide what the back end has to do with this word.
  always_comb begin
    cmd_o.kind = CMD_NONE;
    cmd_o.ip   = item.sender_ip;
    cmd_o.mac  = item.sender_mac;
    if (item.operation == OP_LOOKUP) begin
      cmd_o.kind = CMD_LOOKUP;
      cmd_o.ip   = item.query_ip;
    end else if (item.target_ip == our_ip_i) begin
      case (item.arp_opcode)
        ARP_OPC_REPLY:   cmd_o.kind = CMD_UPDATE;
        ARP_OPC_REQUEST: cmd_o.kind = CMD_ANSWER;
        default:         cmd_o.kind = CMD_NONE;
      endcase
    end
  end

endmodule

### rtl/core/arpc_cmd_fifo.sv
// Short command queue between the front end and the cache engine.
module arpc_cmd_fifo
  import arpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t din_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t dout_o,
  output logic empty_o
);

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

  cmd_t             slot_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign dout_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

### rtl/core/arpc_back.sv
// Cache engine: scans the entry memory, updates it and forms result words.
module arpc_back
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cmd_t          cmd_i,
  output logic          pop_o,
  arpc_stream_if.source result_o
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0] chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  result_t          res_q, res_d;
  logic             out_vld_q, out_vld_d;
  result_t          out_q, out_d;

  // Entry memory: one write and one registered read per cycle.
  logic [31:0]      ip_mem  [CACHE_ENTRIES];
  logic [47:0]      mac_mem [CACHE_ENTRIES];
  logic [31:0]      ip_rd_q;
  logic [47:0]      mac_rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             ip_we, mac_we;

  logic hit, last, miss, issue, out_free;

  // Read data of entry chk_idx_q is present when chk_vld_q is set.
  assign hit      = chk_vld_q && (ip_rd_q == cmd_q.ip);
  assign last     = chk_vld_q && ((chk_idx_q + CNT_W'(1)) == count_q);
  assign miss     = (count_q == '0) || (last && !hit);
  assign issue    = (scan_idx_q < count_q);
  assign out_free = !out_vld_q || result_o.ready;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    scan_idx_d = scan_idx_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    count_d    = count_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !result_o.ready;
    pop_o      = 1'b0;
    rd_addr    = '0;
    wr_addr    = chk_idx_q[IDX_W-1:0];
    ip_we      = 1'b0;
    mac_we     = 1'b0;

    case (state_q)
      // Take the next command and settle the ones that need no search.
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          cmd_d      = cmd_i;
          scan_idx_d = '0;
          chk_vld_d  = 1'b0;
          res_d      = '0;
          case (cmd_i.kind)
            CMD_LOOKUP, CMD_UPDATE: begin
              state_d = ST_SCAN;
            end
            CMD_ANSWER: begin
              res_d.reply_valid   = 1'b1;
              res_d.reply_dst_mac = cmd_i.mac;
              res_d.reply_dst_ip  = cmd_i.ip;
              state_d             = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Read one entry per cycle and compare the one read last cycle.
      ST_SCAN: begin
        rd_addr    = issue ? scan_idx_q[IDX_W-1:0] : '0;
        scan_idx_d = issue ? scan_idx_q + CNT_W'(1) : scan_idx_q;
        chk_vld_d  = issue;
        chk_idx_d  = scan_idx_q;
        if (hit || miss) begin
          state_d   = ST_RESP;
          chk_vld_d = 1'b0;
          if (cmd_q.kind == CMD_LOOKUP) begin
            if (hit) begin
              res_d.found     = 1'b1;
              res_d.found_mac = mac_rd_q;
            end
          end else if (hit) begin
            // Known sender: refresh its MAC.
            mac_we  = 1'b1;
            wr_addr = chk_idx_q[IDX_W-1:0];
          end else if (count_q < FULL_CNT) begin
            // New sender: append after the last filled entry.
            ip_we   = 1'b1;
            mac_we  = 1'b1;
            wr_addr = count_q[IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
          end else begin
            res_d.entry_dropped = 1'b1;
          end
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      count_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      chk_vld_q  <= chk_vld_d;
      chk_idx_q  <= chk_idx_d;
      count_q    <= count_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // Entry memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (ip_we) begin
      ip_mem[wr_addr] <= cmd_q.ip;
    end
    if (mac_we) begin
      mac_mem[wr_addr] <= cmd_q.mac;
    end
    ip_rd_q  <= ip_mem[rd_addr];
    mac_rd_q <= mac_mem[rd_addr];
  end

  assign result_o.valid   = out_vld_q;
  assign result_o.payload = out_q;

endmodule

### rtl/core/arp_cache_responder_core.sv
// Top level of the ARP cache and reply responder.
//
//   channel   | dir | handshake     | word
//   ----------+-----+---------------+-----------------------------------
//   item_i    | in  | valid/ready   | item_t: received ARP or lookup
//   result_o  | out | valid/ready   | result_t: one per input word
//   cfg_*     | in  | write enable  | register index and write data
//
// A lookup or an ARP reply to our address searches the entry memory, one
// read per cycle, through at most the n cached entries until a hit; other
// words need no search and go straight to the result.
// Reset empties the cache at once; there is no clearing pass.
// A two-entry command queue keeps input accepted while the engine or a
// stalled output is busy.
module arp_cache_responder_core
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  arpc_stream_if.sink          item_i,
  arpc_stream_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [31:0] our_ip_q;
  logic        push, full, pop, empty;
  cmd_t        push_cmd, head_cmd;

  // Configuration registers. Our MAC is not used inside this block,
  // so its writes are accepted and discarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_ip_q <= OUR_IP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUR_IP: our_ip_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .our_ip_i (our_ip_q),
    .item_i   (item_i),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  arpc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (head_cmd),
    .empty_o (empty)
  );

  arpc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (head_cmd),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

### rtl/core/arpc_checker.sv
// Port-level checker for the ARP cache top level, with its bind.
`include "arp_cache_responder_core_macros.svh"

module arpc_checker
  import arpc_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_payload_i
);

  logic [2:0] outstanding_q, outstanding_d;
  logic       in_acc, out_acc;
  logic       one_kind, idle_zero;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // A result word carries at most one of hit, reply and drop.
  assign one_kind = $onehot0({out_payload_i.found, out_payload_i.reply_valid,
                              out_payload_i.entry_dropped});

  // Fields that belong to an inactive kind read as zero.
  assign idle_zero = (out_payload_i.found || out_payload_i.found_mac == '0) &&
                     (out_payload_i.reply_valid ||
                      (out_payload_i.reply_dst_mac == '0 && out_payload_i.reply_dst_ip == '0));

  // Words accepted but not yet answered.
  always_comb begin
    outstanding_d = outstanding_q;
    if (in_acc && !out_acc) begin
      outstanding_d = outstanding_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      outstanding_d = outstanding_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  `ARPC_ASSERT(a_one_kind, out_valid_i |-> one_kind, "result mixes hit and reply and drop")
  `ARPC_ASSERT(a_idle_fields, out_valid_i |-> idle_zero, "unused result field not zero")
  `ARPC_ASSERT(a_no_orphan, out_valid_i |-> outstanding_q != 3'd0, "result without a word")
  `ARPC_ASSERT(a_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i), "stalled result changed")
  `ARPC_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind arp_cache_responder_core arpc_checker u_arpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_payload_i (result_o.payload)
);

### sim/tb.sv
// Self-checking testbench for the ARP cache and reply responder core.
module tb;
  import arpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;
  localparam int PHASE_WORDS = 215;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

  // One row of the directed stimulus.
  typedef struct {
    item_t   word;
    bit      fixed;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  arpc_stream_if #(.payload_t(item_t))   item_if ();
  arpc_stream_if #(.payload_t(result_t)) result_if ();

  arp_cache_responder_core #(
    .CACHE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Our copy of the cache and the registers.
  logic [31:0] cache_ip [ENTRIES];
  logic [47:0] cache_mac [ENTRIES];
  int          cache_fill;
  logic [31:0] model_our_ip;
  logic [47:0] model_our_mac;

  result_t     pending_results [$];
  stim_row_t   stim_rows [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int          hold_asked;
  int          hold_served;
  bit          offer_on;
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_hits;
  int          n_replies;
  int          n_drops;
  int          cycle_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic int cache_search(input logic [31:0] ip);
    for (int i = 0; i < cache_fill; i++) begin
      if (cache_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  // Expected result word for one accepted input word; updates the cache copy.
  function automatic result_t arp_predict(input item_t w);
    result_t r;
    int      k;
    r = '0;
    if (w.operation == OP_LOOKUP) begin
      k = cache_search(w.query_ip);
      if (k >= 0) begin
        r.found = 1'b1;
        r.found_mac = cache_mac[k];
        n_hits++;
      end
      return r;
    end
    if (w.target_ip != model_our_ip) return r;
    if (w.arp_opcode == ARP_OPC_REPLY) begin
      k = cache_search(w.sender_ip);
      if (k >= 0) begin
        cache_mac[k] = w.sender_mac;
      end else if (cache_fill < ENTRIES) begin
        cache_ip[cache_fill] = w.sender_ip;
        cache_mac[cache_fill] = w.sender_mac;
        cache_fill++;
      end else begin
        r.entry_dropped = 1'b1;
        n_drops++;
      end
    end else if (w.arp_opcode == ARP_OPC_REQUEST) begin
      r.reply_valid = 1'b1;
      r.reply_dst_mac = w.sender_mac;
      r.reply_dst_ip = w.sender_ip;
      n_replies++;
    end
    return r;
  endfunction

  function automatic item_t mk_item(input logic op, input logic [15:0] opc,
                                    input logic [31:0] sip, input logic [47:0] smac,
                                    input logic [31:0] tip, input logic [31:0] qip);
    item_t w;
    w.operation = op;
    w.arp_opcode = opc;
    w.sender_ip = sip;
    w.sender_mac = smac;
    w.target_ip = tip;
    w.query_ip = qip;
    return w;
  endfunction

  function automatic result_t mk_result(input logic hit, input logic [47:0] fmac,
                                        input logic rv, input logic [47:0] rmac,
                                        input logic [31:0] rip, input logic drop);
    result_t r;
    r.found = hit;
    r.found_mac = fmac;
    r.reply_valid = rv;
    r.reply_dst_mac = rmac;
    r.reply_dst_ip = rip;
    r.entry_dropped = drop;
    return r;
  endfunction

  function automatic void add_row(input item_t w, input bit fixed, input result_t want);
    stim_row_t row;
    row.word = w;
    row.fixed = fixed;
    row.want = want;
    stim_rows.push_back(row);
  endfunction

  // Drop valid once; a second lowering in the same step is never issued.
  task automatic lower_valid();
    if (offer_on) begin
      item_if.valid <= 1'b0;
      offer_on = 1'b0;
    end
  endtask

  // Offer one word, wait for its acceptance, then idle at random.
  task automatic send_word(input item_t w, input bit fixed, input result_t want);
    result_t pred;
    item_if.valid <= 1'b1;
    item_if.payload <= w;
    offer_on = 1'b1;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    pred = arp_predict(w);
    pending_results.push_back(fixed ? want : pred);
    n_sent++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      lower_valid();
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected word has come out.
  task automatic drain();
    lower_valid();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic write_config(input logic [31:0] ip, input logic [47:0] mac);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_OUR_IP;
    cfg_wdata <= {junk, ip};
    @(posedge clk);
    model_our_ip = ip;
    cfg_idx <= CFG_OUR_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    model_our_mac = mac;
    cfg_we <= 1'b0;
  endtask

  // Compare one output word with the oldest expectation, field by field.
  task automatic check_word(input result_t got);
    result_t want;
    bit      bad;
    bad = 1'b0;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected word: expected none, actual %0h", $time, got);
      n_errors++;
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    if (got.found !== want.found) begin
      $display("%0t: found: expected %0h, actual %0h", $time, want.found, got.found);
      bad = 1'b1;
    end
    if (got.found_mac !== want.found_mac) begin
      $display("%0t: found_mac: expected %0h, actual %0h", $time, want.found_mac,
               got.found_mac);
      bad = 1'b1;
    end
    if (got.reply_valid !== want.reply_valid) begin
      $display("%0t: reply_valid: expected %0h, actual %0h", $time, want.reply_valid,
               got.reply_valid);
      bad = 1'b1;
    end
    if (got.reply_dst_mac !== want.reply_dst_mac) begin
      $display("%0t: reply_dst_mac: expected %0h, actual %0h", $time, want.reply_dst_mac,
               got.reply_dst_mac);
      bad = 1'b1;
    end
    if (got.reply_dst_ip !== want.reply_dst_ip) begin
      $display("%0t: reply_dst_ip: expected %0h, actual %0h", $time, want.reply_dst_ip,
               got.reply_dst_ip);
      bad = 1'b1;
    end
    if (got.entry_dropped !== want.entry_dropped) begin
      $display("%0t: entry_dropped: expected %0h, actual %0h", $time, want.entry_dropped,
               got.entry_dropped);
      bad = 1'b1;
    end
    if (bad) n_errors++;
  endtask

  // Result side: check every word taken from the block.
  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) check_word(result_if.payload);
  end

  // Receiver ready: random idling, or a long hold-off when one is asked for.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus: directed rows, then random phases over several settings.
  initial begin
    item_t       w;
    logic [31:0] phase_ip [6];
    logic [47:0] phase_mac [6];
    int unsigned pick;
    item_if.valid = 1'b0;
    item_if.payload = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    offer_on = 1'b0;
    cache_fill = 0;
    model_our_ip = OUR_IP_RESET;
    model_our_mac = '0;
    tx_idle_pct = 7;
    rx_idle_pct = 81;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the reset values of both registers.
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, 16'hFFFF, '1, MAC_ONES, OUR_IP_RESET, '1), 1'b1, '0);
    add_row(mk_item(OP_PACKET, ARP_OPC_REQUEST, '1, MAC_ONES, OUR_IP_RESET, 32'h0), 1'b1,
            mk_result(1'b0, '0, 1'b1, MAC_ONES, '1, 1'b0));
    add_row(mk_item(OP_PACKET, ARP_OPC_REQUEST, 32'h0, 48'h0, OUR_IP_RESET, '1), 1'b1,
            mk_result(1'b0, '0, 1'b1, '0, '0, 1'b0));
    // Opcodes other than request and reply do nothing.
    add_row(mk_item(OP_PACKET, 16'h0, 32'h5, 48'h5, OUR_IP_RESET, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_PACKET, 16'hFFFF, 32'h6, 48'h6, OUR_IP_RESET, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_PACKET, 16'h3, 32'h7, 48'h7, OUR_IP_RESET, 32'h0), 1'b1, '0);
    // A target that is not ours leaves the cache alone.
    add_row(mk_item(OP_PACKET, ARP_OPC_REPLY, 32'hC0A80001, 48'hA1, OUR_IP_RESET ^ 32'h1,
                    32'h0), 1'b1, '0);
    add_row(mk_item(OP_PACKET, ARP_OPC_REQUEST, 32'h1, 48'h1, 32'h0, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'hC0A80001), 1'b1, '0);
    // Fill two entries at the address extremes, then hit them.
    add_row(mk_item(OP_PACKET, ARP_OPC_REPLY, 32'h0, MAC_ONES, OUR_IP_RESET, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_PACKET, ARP_OPC_REPLY, '1, 48'h0, OUR_IP_RESET, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0), 1'b1,
            mk_result(1'b1, MAC_ONES, 1'b0, '0, '0, 1'b0));
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, '1), 1'b1,
            mk_result(1'b1, '0, 1'b0, '0, '0, 1'b0));
    // A reply for a cached address updates its MAC in place.
    add_row(mk_item(OP_PACKET, ARP_OPC_REPLY, 32'h0, 48'h1234_5678_9ABC, OUR_IP_RESET,
                    32'h0), 1'b1, '0);
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0), 1'b1,
            mk_result(1'b1, 48'h1234_5678_9ABC, 1'b0, '0, '0, 1'b0));
    // A lookup word that also looks like a reply only searches.
    add_row(mk_item(OP_LOOKUP, ARP_OPC_REPLY, 32'h0A0A0A0A, 48'hBEEF, OUR_IP_RESET, '1),
            1'b1, mk_result(1'b1, '0, 1'b0, '0, '0, 1'b0));
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0A0A0A0A), 1'b1, '0);
    add_row(mk_item(OP_PACKET, ARP_OPC_REQUEST, 32'h0, 48'h0000_5555_AAAA, OUR_IP_RESET,
                    32'h0), 1'b0, '0);
    // High opcode bits make a reply code into an unknown opcode.
    add_row(mk_item(OP_PACKET, 16'h8002, 32'h9, 48'h9, OUR_IP_RESET, 32'h0), 1'b1, '0);
    add_row(mk_item(OP_PACKET, ARP_OPC_REPLY, OUR_IP_RESET, rand48(), OUR_IP_RESET, 32'h0),
            1'b0, '0);
    add_row(mk_item(OP_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, OUR_IP_RESET), 1'b0, '0);
    add_row(mk_item(OP_LOOKUP, 16'hFFFF, '1, MAC_ONES, '1, 32'h0), 1'b0, '0);

    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].fixed, stim_rows[i].want);
    drain();

    // Register settings per random phase, extremes first.
    phase_ip[0] = '1;            phase_mac[0] = MAC_ONES;
    phase_ip[1] = '0;            phase_mac[1] = '0;
    phase_ip[2] = $urandom;      phase_mac[2] = rand48();
    phase_ip[3] = OUR_IP_RESET;  phase_mac[3] = rand48();
    phase_ip[4] = $urandom;      phase_mac[4] = MAC_ONES;
    phase_ip[5] = $urandom;      phase_mac[5] = rand48();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_config(phase_ip[p], phase_mac[p]);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // With no idling, stall the receiver once while words keep coming.
        if (p == 4 && n == 60) hold_asked++;
        w.operation = OP_PACKET;
        w.arp_opcode = 16'($urandom);
        w.sender_ip = $urandom;
        w.sender_mac = rand48();
        w.target_ip = $urandom;
        w.query_ip = $urandom;
        if ($urandom_range(0, 99) < 40) begin
          w.operation = OP_LOOKUP;
          if (cache_fill > 0 && $urandom_range(0, 99) < 70) begin
            w.query_ip = cache_ip[$urandom_range(0, cache_fill - 1)];
          end
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            w.arp_opcode = ARP_OPC_REPLY;
          end else if (pick < 80) begin
            w.arp_opcode = ARP_OPC_REQUEST;
          end
          if ($urandom_range(0, 99) < 80) w.target_ip = model_our_ip;
          pick = $urandom_range(0, 99);
          if (pick < 50 && cache_fill > 0) begin
            w.sender_ip = cache_ip[$urandom_range(0, cache_fill - 1)];
          end else if (pick < 55) begin
            w.sender_ip = model_our_ip;
          end
        end
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    // Let any stray word show up before the verdict.
    repeat (40) @(posedge clk);
    n_errors += pending_results.size();
    $display("Sent %0d words and checked %0d results over six register settings.",
             n_sent, n_checked);
    $display("Lookup hits %0d, replies asked %0d, dropped on full cache %0d.",
             n_hits, n_replies, n_drops);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
